/* hw/rtl/saalu_pkg.sv */
// Shared opcodes, limits and stage records for the Q16.16 saturating ALU.
// No dependencies; the prep, divider stage and top-level files refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package saalu_pkg;

    localparam logic [3:0] OP_FROM_INT   = 4'd0;
    localparam logic [3:0] OP_FROM_FLOAT = 4'd1;
    localparam logic [3:0] OP_TO_INT     = 4'd2;
    localparam logic [3:0] OP_TO_FLOAT   = 4'd3;
    localparam logic [3:0] OP_ADD        = 4'd4;
    localparam logic [3:0] OP_SUB        = 4'd5;
    localparam logic [3:0] OP_MUL        = 4'd6;
    localparam logic [3:0] OP_DIV        = 4'd7;
    localparam logic [3:0] OP_NEG        = 4'd8;
    localparam logic [3:0] OP_ACC        = 4'd9;

    localparam logic [31:0] RAW_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] RAW_MIN = 32'h8000_0000;

    // Second stage: operand decode, product and conversion pre-work.
    typedef struct packed {
        logic [3:0]         op;
        logic [31:0]        simple;
        logic signed [65:0] prod;
        logic [63:0]        fmag;
        logic               fsign;
        logic               fnan;
        logic               finf;
        logic [31:0]        tmag;
        logic [4:0]         tp;
        logic               tsign;
        logic [31:0]        amag;
        logic [31:0]        bmag;
        logic               dsign;
        logic               bzero;
    } t_prep;

    // Everything that rides beside the divider chain.
    typedef struct packed {
        logic        is_div;
        logic        dsign;
        logic        bzero;
        logic [31:0] res;
        logic [31:0] fo;
        logic        ok;
    } t_side;

endpackage
`default_nettype wire

/* hw/rtl/saalu_prep.sv */
// Second pipeline stage of the saturating ALU: simple ops, product, conversion pre-work.
// Depends on saalu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module saalu_prep #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [3:0]         i_op,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    input  wire logic [31:0]        i_fin,
    input  wire logic [31:0]        i_cnt,
    output saalu_pkg::t_prep        o_prep
);

    saalu_pkg::t_prep   n_prep;
    saalu_pkg::t_prep   r_prep;
    logic signed [63:0] wide_a;
    logic [32:0]        sum;
    logic [32:0]        dif;
    logic [31:0]        from_int_res;
    logic signed [32:0] mx;
    logic signed [32:0] my;
    logic [7:0]         ex;
    logic [23:0]        man;
    logic signed [9:0]  sh;
    logic [9:0]         nsh;
    logic [31:0]        tmag;

    always_comb begin
        wide_a = 64'(i_a) <<< FRACTION_BITS;
        if (wide_a[63:31] == {33{1'b0}} || wide_a[63:31] == {33{1'b1}}) begin
            from_int_res = wide_a[31:0];
        end else begin
            from_int_res = wide_a[63] ? saalu_pkg::RAW_MIN : saalu_pkg::RAW_MAX;
        end
        sum = {i_a[31], i_a} + {i_b[31], i_b};
        dif = {i_a[31], i_a} - {i_b[31], i_b};

        n_prep    = '0;
        n_prep.op = i_op;
        case (i_op)
            saalu_pkg::OP_FROM_INT: n_prep.simple = from_int_res;
            saalu_pkg::OP_TO_INT:   n_prep.simple = 32'(i_a >>> FRACTION_BITS);
            saalu_pkg::OP_ADD: begin
                if (sum[32] != sum[31]) begin
                    n_prep.simple = sum[32] ? saalu_pkg::RAW_MIN : saalu_pkg::RAW_MAX;
                end else begin
                    n_prep.simple = sum[31:0];
                end
            end
            saalu_pkg::OP_SUB: begin
                if (dif[32] != dif[31]) begin
                    n_prep.simple = dif[32] ? saalu_pkg::RAW_MIN : saalu_pkg::RAW_MAX;
                end else begin
                    n_prep.simple = dif[31:0];
                end
            end
            saalu_pkg::OP_NEG: begin
                n_prep.simple = (i_a == saalu_pkg::RAW_MIN) ? saalu_pkg::RAW_MAX
                                                            : (~i_a + 32'd1);
            end
            default: n_prep.simple = '0;
        endcase

        // One shared multiplier: a*b for mul, a*count for accumulate.
        mx = {i_a[31], i_a};
        my = (i_op == saalu_pkg::OP_ACC) ? {1'b0, i_cnt} : {i_b[31], i_b};
        n_prep.prod = 66'(mx) * 66'(my);

        // Single to fixed: align the mantissa, rounding halves away from zero.
        ex  = i_fin[30:23];
        man = (ex == 8'd0) ? {1'b0, i_fin[22:0]} : {1'b1, i_fin[22:0]};
        sh  = $signed({2'b00, (ex == 8'd0) ? 8'd1 : ex}) - 10'sd150
              + $signed(10'(FRACTION_BITS));
        nsh = 10'(-sh);
        if (!sh[9]) begin
            if (sh > 10'sd39) begin
                n_prep.fmag = 64'h1_0000_0000;
            end else begin
                n_prep.fmag = 64'(man) << sh[5:0];
            end
        end else if (nsh >= 10'd25) begin
            n_prep.fmag = '0;
        end else begin
            n_prep.fmag = (64'(man) + (64'd1 << (nsh[4:0] - 5'd1))) >> nsh[4:0];
        end
        n_prep.fsign = i_fin[31];
        n_prep.fnan  = (ex == 8'hFF) && (i_fin[22:0] != 23'd0);
        n_prep.finf  = (ex == 8'hFF) && (i_fin[22:0] == 23'd0);

        // Fixed to single: magnitude and its leading one position.
        tmag = i_a[31] ? (~i_a + 32'd1) : i_a;
        n_prep.tmag  = tmag;
        n_prep.tsign = i_a[31];
        n_prep.tp    = '0;
        for (int i = 0; i < 32; i++) begin
            if (tmag[i]) begin
                n_prep.tp = 5'(i);
            end
        end

        // Divider operands as magnitudes.
        n_prep.amag  = tmag;
        n_prep.bmag  = i_b[31] ? (~i_b + 32'd1) : i_b;
        n_prep.dsign = i_a[31] ^ i_b[31];
        n_prep.bzero = (i_b == 32'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prep <= n_prep;
        end
    end

    assign o_prep = r_prep;

endmodule
`default_nettype wire

/* hw/rtl/saalu_div_stage.sv */
// One restoring step of the pipelined divider: one quotient bit per stage.
// Depends on saalu_pkg for the record carried beside the divider.
`timescale 1ns / 1ps
`default_nettype none
module saalu_div_stage #(
    parameter int NUM_W = 48
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [31:0]      i_rem,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [NUM_W-1:0] i_quo,
    input  wire logic [31:0]      i_d,
    input  saalu_pkg::t_side      i_side,
    output logic [31:0]           o_rem,
    output logic [NUM_W-1:0]      o_num,
    output logic [NUM_W-1:0]      o_quo,
    output logic [31:0]           o_d,
    output saalu_pkg::t_side      o_side
);

    logic [32:0]      cur;
    logic [33:0]      diff;
    logic [31:0]      n_rem;
    logic             qbit;
    logic [31:0]      r_rem;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quo;
    logic [31:0]      r_d;
    saalu_pkg::t_side r_side;

    always_comb begin
        cur  = {i_rem, i_num[NUM_W-1]};
        diff = {1'b0, cur} - {2'b00, i_d};
        qbit = !diff[33];
        // The partial remainder stays below the divisor, so 32 bits hold it.
        n_rem = qbit ? diff[31:0] : cur[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_num  <= {i_num[NUM_W-2:0], 1'b0};
            r_quo  <= {i_quo[NUM_W-2:0], qbit};
            r_d    <= i_d;
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_num  = r_num;
    assign o_quo  = r_quo;
    assign o_d    = r_d;
    assign o_side = r_side;

endmodule
`default_nettype wire

/* hw/rtl/q16_16_saturating_alu.sv */
// Top level of the pipelined Q16.16 saturating ALU.
// Depends on saalu_pkg, saalu_prep and saalu_div_stage.
//
// Usage: one word enters on the slave stream (i_s_*) and one result word leaves
// on the master stream (o_m_*) for each, in order. The input word carries the
// opcode in i_s_tuser and the operands in i_s_tdata; the result carries the
// saturated fixed result and the single-precision pattern in o_m_tdata and
// the ok flag in o_m_tuser.
// From acceptance to o_m_tvalid a word passes, in order, an input register, a
// decode/multiply stage, one divider stage per quotient bit (32 + FRACTION_BITS
// of them, with FRACTION_BITS = 16 for Q16.16; the restoring divider sets the
// depth), and the output register. Every opcode takes the same path, so
// results never reorder.
// Throughput is one word per cycle. The whole pipeline advances together while
// the output register is empty or being taken; when the receiver holds off
// with a result waiting, every stage holds and o_s_tready drops, so nothing
// is lost or repeated. Bubbles in the pipeline still move forward while the
// output is empty.
// A synchronous active-low reset clears all valid bits; payload is left as is.
`timescale 1ns / 1ps
`default_nettype none
module q16_16_saturating_alu #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // [31:0] operand_a, [63:32] operand_b, [95:64] float_in, [127:96] repeat_count
    input  wire logic [127:0] i_s_tdata,
    // [3:0] op
    input  wire logic [3:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // [31:0] result, [63:32] float_out
    output logic [63:0]       o_m_tdata,
    // [0] ok
    output logic [0:0]        o_m_tuser
);

    localparam int NUM_W = 32 + FRACTION_BITS;

    logic               en;

    // Input register stage.
    logic               r_v1;
    logic [3:0]         r1_op;
    logic signed [31:0] r1_a;
    logic signed [31:0] r1_b;
    logic [31:0]        r1_fin;
    logic [31:0]        r1_cnt;

    // Decode stage.
    logic               r_v2;
    saalu_pkg::t_prep   w_prep;

    // Finishing logic for everything but the divider.
    saalu_pkg::t_side   n_side;
    logic signed [65:0] mul_sh;
    logic [5:0]         pe;
    logic [3:0]         nrnd;
    logic [31:0]        rem_bits;
    logic [31:0]        half;
    logic [24:0]        q;
    logic [8:0]         fexp;

    // Divider chain.
    logic [31:0]        w_rem  [NUM_W+1];
    logic [NUM_W-1:0]   w_num  [NUM_W+1];
    logic [NUM_W-1:0]   w_quo  [NUM_W+1];
    logic [31:0]        w_d    [NUM_W+1];
    saalu_pkg::t_side   w_side [NUM_W+1];
    logic               r_vd   [NUM_W];

    // Output register.
    logic               r_ovld;
    logic [31:0]        r_res;
    logic [31:0]        r_fo;
    logic               r_ok;
    logic [31:0]        n_res;
    logic               n_ok;
    logic [NUM_W-1:0]   qf;
    saalu_pkg::t_side   sf;

    function automatic logic [31:0] sat66(input logic signed [65:0] v);
        if (v[65:31] == {35{1'b0}} || v[65:31] == {35{1'b1}}) begin
            return v[31:0];
        end
        return v[65] ? saalu_pkg::RAW_MIN : saalu_pkg::RAW_MAX;
    endfunction

    // The pipeline moves as one whenever the output register can take a word.
    assign en         = !r_ovld || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op  <= i_s_tuser;
            r1_a   <= i_s_tdata[31:0];
            r1_b   <= i_s_tdata[63:32];
            r1_fin <= i_s_tdata[95:64];
            r1_cnt <= i_s_tdata[127:96];
        end
    end

    saalu_prep #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_prep (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_op   (r1_op),
        .i_a    (r1_a),
        .i_b    (r1_b),
        .i_fin  (r1_fin),
        .i_cnt  (r1_cnt),
        .o_prep (w_prep)
    );

    // Finish every non-divide opcode here; the result then rides beside the
    // divider so that all opcodes share one latency.
    always_comb begin
        n_side        = '0;
        n_side.ok     = 1'b1;
        n_side.dsign  = w_prep.dsign;
        n_side.bzero  = w_prep.bzero;
        mul_sh        = w_prep.prod >>> FRACTION_BITS;
        pe            = {1'b0, w_prep.tp};
        nrnd          = '0;
        rem_bits      = '0;
        half          = '0;
        q             = '0;
        fexp          = '0;

        // Normalize to a 24-bit significand, round to nearest even.
        if (w_prep.tp <= 5'd23) begin
            q = 25'(w_prep.tmag << (5'd23 - w_prep.tp));
        end else begin
            nrnd     = 4'(w_prep.tp - 5'd23);
            rem_bits = w_prep.tmag & ((32'd1 << nrnd) - 32'd1);
            half     = 32'd1 << (nrnd - 4'd1);
            q        = 25'(w_prep.tmag >> nrnd);
            if (rem_bits > half || (rem_bits == half && q[0])) begin
                q = q + 25'd1;
            end
            if (q[24]) begin
                q  = q >> 1;
                pe = pe + 6'd1;
            end
        end
        fexp = 9'(pe) + 9'd127 - 9'(FRACTION_BITS);

        case (w_prep.op)
            saalu_pkg::OP_FROM_INT,
            saalu_pkg::OP_TO_INT,
            saalu_pkg::OP_ADD,
            saalu_pkg::OP_SUB,
            saalu_pkg::OP_NEG: n_side.res = w_prep.simple;
            saalu_pkg::OP_FROM_FLOAT: begin
                if (w_prep.fnan) begin
                    n_side.res = '0;
                end else if (w_prep.finf) begin
                    n_side.res = w_prep.fsign ? saalu_pkg::RAW_MIN : saalu_pkg::RAW_MAX;
                end else if (w_prep.fsign) begin
                    n_side.res = (w_prep.fmag >= 64'h8000_0000) ? saalu_pkg::RAW_MIN
                                 : (~w_prep.fmag[31:0] + 32'd1);
                end else begin
                    n_side.res = (w_prep.fmag > 64'h7FFF_FFFF) ? saalu_pkg::RAW_MAX
                                 : w_prep.fmag[31:0];
                end
            end
            saalu_pkg::OP_TO_FLOAT: begin
                if (w_prep.tmag == 32'd0) begin
                    n_side.fo = '0;
                end else begin
                    n_side.fo = {w_prep.tsign, fexp[7:0], q[22:0]};
                end
            end
            saalu_pkg::OP_MUL: n_side.res = sat66(mul_sh);
            saalu_pkg::OP_ACC: n_side.res = sat66(w_prep.prod);
            saalu_pkg::OP_DIV: n_side.is_div = 1'b1;
            default:           n_side.ok = 1'b0;
        endcase
    end

    // Head of the divider: |a| scaled by the fraction width over |b|.
    assign w_rem[0]  = '0;
    assign w_num[0]  = NUM_W'(w_prep.amag) << FRACTION_BITS;
    assign w_quo[0]  = '0;
    assign w_d[0]    = w_prep.bmag;
    assign w_side[0] = n_side;

    for (genvar g = 0; g < NUM_W; g++) begin : g_div
        saalu_div_stage #(
            .NUM_W (NUM_W)
        ) u_stage (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (w_rem[g]),
            .i_num  (w_num[g]),
            .i_quo  (w_quo[g]),
            .i_d    (w_d[g]),
            .i_side (w_side[g]),
            .o_rem  (w_rem[g+1]),
            .o_num  (w_num[g+1]),
            .o_quo  (w_quo[g+1]),
            .o_d    (w_d[g+1]),
            .o_side (w_side[g+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[g] <= 1'b0;
            end else if (en) begin
                r_vd[g] <= (g == 0) ? r_v2 : r_vd[(g == 0) ? 0 : g-1];
            end
        end
    end

    // Apply the quotient sign and saturate; a zero divisor gives zero and !ok.
    always_comb begin
        qf    = w_quo[NUM_W];
        sf    = w_side[NUM_W];
        n_res = sf.res;
        n_ok  = sf.ok;
        if (sf.is_div) begin
            if (sf.bzero) begin
                n_res = '0;
                n_ok  = 1'b0;
            end else if (sf.dsign) begin
                n_res = (qf > NUM_W'(64'h8000_0000)) ? saalu_pkg::RAW_MIN
                        : (~qf[31:0] + 32'd1);
            end else begin
                n_res = (qf > NUM_W'(64'h7FFF_FFFF)) ? saalu_pkg::RAW_MAX : qf[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r_vd[NUM_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
            r_fo  <= sf.fo;
            r_ok  <= n_ok;
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {r_fo, r_res};
    assign o_m_tuser  = r_ok;

endmodule
`default_nettype wire

/* hw/rtl/saalu_checker.sv */
// Port-level checks for the saturating ALU, bound to the top level.
// Depends only on the ports of q16_16_saturating_alu.
`timescale 1ns / 1ps
`default_nettype none
module saalu_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_tvalid,
    input wire logic         o_s_tready,
    input wire logic [127:0] i_s_tdata,
    input wire logic [3:0]   i_s_tuser,
    input wire logic         o_m_tvalid,
    input wire logic         i_m_tready,
    input wire logic [63:0]  o_m_tdata,
    input wire logic [0:0]   o_m_tuser
);

    // A result waiting on the receiver stays put.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed or vanished while stalled");

    // With the output register empty the block always takes a word.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input not ready with an empty output");

    // Stalled output must back-pressure the input.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted while the output is stalled");

    // A failed operation reports all-zero data.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == 64'd0)
        else $error("nonzero data with ok low");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind q16_16_saturating_alu saalu_checker u_saalu_checker (.*);
`default_nettype wire
